@@ design/bedc_pkg.sv @@
// Shared types and codes for the bounded edit distance check.
// Used by bedc_ctrl, bedc_dp, bounded_edit_distance_check, bedc_checker and the testbench; no dependencies.
`timescale 1ns / 1ps

package bedc_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_TARGET = 2'd1,
        OP_SOURCE = 2'd2,
        OP_FINISH = 2'd3
    } op_t;

    typedef enum logic [6:0] {
        ST_INIT   = 7'b0000001,
        ST_CLR    = 7'b0000010,
        ST_IDLE   = 7'b0000100,
        ST_BUILD  = 7'b0001000,
        ST_STEP   = 7'b0010000,
        ST_VERD   = 7'b0100000,
        ST_REPORT = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_STEP    = 2'd1,
        MODE_VERDICT = 2'd2
    } mode_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic tgt_store;
        logic set_ovf;
        logic build_start;
        logic step_start;
        logic verd_start;
        logic load_result;
    } cmd_t;

    typedef struct packed {
        logic built;
        logic tgt_full;
        logic src_full;
        logic ovf;
        logic build_done;
        logic sweep_done;
        logic busy;
    } status_t;

endpackage

@@ design/bedc_ctrl.sv @@
// Controller state machine for the bounded edit distance check.
// Depends on bedc_pkg; drives bedc_dp through command and status structs.
`timescale 1ns / 1ps

module bedc_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    output logic               out_valid,
    input  logic               out_ready,
    input  bedc_pkg::status_t  st,
    output bedc_pkg::cmd_t     cmd
);

    bedc_pkg::state_t state_reg;
    bedc_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            bedc_pkg::ST_INIT:
            begin
                cmd.clear  = 1'b1;
                state_next = bedc_pkg::ST_CLR;
            end
            bedc_pkg::ST_CLR:
            begin
                if (st.sweep_done)
                begin
                    state_next = bedc_pkg::ST_IDLE;
                end
            end
            bedc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    unique case (bedc_pkg::op_t'(operation))
                        bedc_pkg::OP_CLEAR:
                        begin
                            cmd.clear  = 1'b1;
                            state_next = bedc_pkg::ST_CLR;
                        end
                        bedc_pkg::OP_TARGET:
                        begin
                            if (!st.built)
                            begin
                                if (st.tgt_full)
                                begin
                                    cmd.set_ovf = 1'b1;
                                end
                                else
                                begin
                                    cmd.tgt_store = 1'b1;
                                end
                            end
                        end
                        bedc_pkg::OP_SOURCE:
                        begin
                            if (st.src_full)
                            begin
                                cmd.set_ovf = 1'b1;
                            end
                            else if (!st.built)
                            begin
                                cmd.build_start = 1'b1;
                                state_next      = bedc_pkg::ST_BUILD;
                            end
                            else
                            begin
                                cmd.step_start = 1'b1;
                                state_next     = bedc_pkg::ST_STEP;
                            end
                        end
                        bedc_pkg::OP_FINISH:
                        begin
                            if (st.ovf)
                            begin
                                state_next = bedc_pkg::ST_REPORT;
                            end
                            else
                            begin
                                cmd.verd_start = 1'b1;
                                state_next     = bedc_pkg::ST_VERD;
                            end
                        end
                    endcase
                end
            end
            bedc_pkg::ST_BUILD:
            begin
                if (st.build_done)
                begin
                    cmd.step_start = 1'b1;
                    state_next     = bedc_pkg::ST_STEP;
                end
            end
            bedc_pkg::ST_STEP:
            begin
                if (st.sweep_done)
                begin
                    state_next = bedc_pkg::ST_IDLE;
                end
            end
            bedc_pkg::ST_VERD:
            begin
                if (st.sweep_done)
                begin
                    state_next = bedc_pkg::ST_REPORT;
                end
            end
            bedc_pkg::ST_REPORT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = bedc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bedc_pkg::ST_INIT;
            end
        endcase
    end

    // A new result takes precedence over the transfer of the old one.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bedc_pkg::ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == bedc_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ design/bedc_dp.sv @@
// Datapath for the bounded edit distance check: target store, next-occurrence
// rows, double-banked reach table and the sweep pipeline. Depends on bedc_pkg.
`timescale 1ns / 1ps

module bedc_dp
#(
    parameter int MAX_TARGET = 1024,
    parameter int MAX_EDITS  = 20,
    parameter int ALPHABET   = 26
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [4:0]         cfg_data,
    input  logic [4:0]         symbol,
    input  bedc_pkg::cmd_t     cmd,
    output bedc_pkg::status_t  st,
    output logic               within_limit,
    output logic               length_overflow
);

    localparam int PW  = $clog2(MAX_TARGET + 1);
    localparam int AW  = $clog2(MAX_TARGET);
    localparam int EW  = $clog2(MAX_EDITS + 1);
    localparam int TRI = (MAX_EDITS + 1) * (MAX_EDITS + 2) / 2;
    localparam int TW  = $clog2(TRI);
    localparam int NW  = $clog2(MAX_TARGET + MAX_EDITS + 1);
    localparam int SW  = NW + 2;
    localparam int CW  = $clog2(ALPHABET);
    localparam int RW  = PW + 1;

    // Configuration and string bookkeeping.
    logic [4:0]    edit_limit_reg;
    logic [4:0]    sym_reg;
    logic [PW-1:0] m_reg;
    logic [NW-1:0] n_reg;
    logic          ovf_reg;
    logic          built_reg;
    logic          bank_reg;
    logic          verd_reg;
    logic          within_reg;
    logic          lovf_reg;

    logic [EW-1:0] k_lim;
    logic          sym_ok;
    logic [CW-1:0] sym_idx;

    // Table build engine.
    logic                          b_run_reg;
    logic                          b_read_reg;
    logic [PW-1:0]                 bp_reg;
    logic [ALPHABET-1:0][PW-1:0]   vec_reg;
    logic [4:0]                    tgt_mem [MAX_TARGET];
    logic [4:0]                    tgt_rdata;
    logic [ALPHABET-1:0][PW-1:0]   nxt_mem [MAX_TARGET + 1];
    logic [ALPHABET-1:0][PW-1:0]   nxt_rdata;
    logic                          b_write;

    // Sweep pipeline over the reach table.
    logic              sw_run_reg;
    bedc_pkg::mode_t   mode_reg;
    logic [EW-1:0]     j_reg;
    logic [EW-1:0]     l_reg;
    logic [TW-1:0]     idx_reg;
    logic [RW-1:0]     reach_mem [2][TRI];
    logic [RW-1:0]     rd_a;
    logic [RW-1:0]     rd_b;
    logic [RW-1:0]     prevb_reg;

    logic              p1_v_reg;
    logic [EW-1:0]     p1_j_reg;
    logic [EW-1:0]     p1_l_reg;
    logic [TW-1:0]     p1_idx_reg;
    logic              p1_last_reg;

    logic              p2_v_reg;
    logic [TW-1:0]     p2_idx_reg;
    logic              p2_last_reg;
    logic              p2_ds_v_reg;
    logic [PW-1:0]     p2_ds_p_reg;
    logic              p2_mt_en_reg;
    logic              hit_reg;

    logic              in_k;
    logic              del_ok;
    logic              sub_ok;
    logic [PW-1:0]     sub_p;
    logic              ds_v;
    logic [PW-1:0]     ds_p;
    logic [SW-1:0]     e_val;
    logic [SW-1:0]     e_abs;
    logic              e_hit;
    logic [SW-1:0]     d_val;
    logic [SW-1:0]     d_abs;
    logic              dist_over;
    logic [PW-1:0]     q_pos;
    logic              mt_ok;
    logic [PW-1:0]     mt_p;
    logic [RW-1:0]     wr_data;
    logic              wr_en;
    logic              wr_bank;
    logic              sw_last;
    logic              sweep_start;

    assign k_lim   = (32'(edit_limit_reg) > MAX_EDITS) ? EW'(MAX_EDITS) : EW'(edit_limit_reg);
    assign sym_ok  = (32'(sym_reg) < ALPHABET);
    assign sym_idx = CW'(sym_reg);

    assign b_write     = b_run_reg && !b_read_reg;
    assign sw_last     = (idx_reg == TW'(TRI - 1));
    assign sweep_start = cmd.clear || cmd.step_start || cmd.verd_start;

    // Stage one: gather the deletion and substitution candidates for (j, l) and the verdict tests.
    always_comb
    begin
        in_k   = (p1_j_reg <= k_lim);
        del_ok = (p1_l_reg != '0) && in_k && prevb_reg[PW];
        sub_ok = (p1_l_reg < p1_j_reg) && in_k && rd_b[PW] && (rd_b[PW-1:0] < m_reg);
        sub_p  = rd_b[PW-1:0] + PW'(1);
        ds_v   = del_ok || sub_ok;
        if (del_ok && (!sub_ok || prevb_reg[PW-1:0] <= sub_p))
        begin
            ds_p = prevb_reg[PW-1:0];
        end
        else
        begin
            ds_p = sub_p;
        end
        e_val = SW'(n_reg) - SW'(m_reg) - SW'(p1_l_reg);
        e_abs = e_val[SW-1] ? (SW'(0) - e_val) : e_val;
        e_hit = rd_a[PW] && in_k && (e_abs <= SW'(k_lim - p1_j_reg));
        d_val = SW'(n_reg) - SW'(m_reg);
        d_abs = d_val[SW-1] ? (SW'(0) - d_val) : d_val;
        dist_over = (d_abs > SW'(k_lim));
    end

    // Stage two: the match candidate, then the minimum of all candidates; clear mode writes the initial table.
    always_comb
    begin
        q_pos = nxt_rdata[sym_idx];
        mt_ok = p2_mt_en_reg && (q_pos < m_reg);
        mt_p  = q_pos + PW'(1);
        if (mode_reg == bedc_pkg::MODE_CLEAR)
        begin
            wr_data = (p2_idx_reg == '0) ? {1'b1, PW'(0)} : '0;
        end
        else if (mt_ok && (!p2_ds_v_reg || mt_p <= p2_ds_p_reg))
        begin
            wr_data = {1'b1, mt_p};
        end
        else if (p2_ds_v_reg)
        begin
            wr_data = {1'b1, p2_ds_p_reg};
        end
        else
        begin
            wr_data = '0;
        end
        wr_en   = p2_v_reg && (mode_reg != bedc_pkg::MODE_VERDICT);
        wr_bank = (mode_reg == bedc_pkg::MODE_CLEAR) ? bank_reg : !bank_reg;
    end

    // Memories.
    always_ff @(posedge clk)
    begin
        if (cmd.tgt_store)
        begin
            tgt_mem[m_reg[AW-1:0]] <= symbol;
        end
        tgt_rdata <= tgt_mem[AW'(bp_reg - PW'(1))];
    end

    always_ff @(posedge clk)
    begin
        if (b_write)
        begin
            nxt_mem[bp_reg] <= vec_reg;
        end
        nxt_rdata <= nxt_mem[rd_a[PW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            reach_mem[wr_bank][p2_idx_reg] <= wr_data;
        end
        rd_a <= reach_mem[bank_reg][idx_reg];
        rd_b <= reach_mem[bank_reg][idx_reg - TW'(j_reg)];
    end

    // Payload registers without reset.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sym_reg <= symbol;
        end
        if (cmd.build_start)
        begin
            for (int c = 0; c < ALPHABET; c++)
            begin
                vec_reg[c] <= m_reg;
            end
        end
        else if (b_run_reg && b_read_reg)
        begin
            for (int c = 0; c < ALPHABET; c++)
            begin
                if (32'(tgt_rdata) == c)
                begin
                    vec_reg[c] <= bp_reg;
                end
            end
        end
        if (p1_v_reg)
        begin
            prevb_reg <= rd_b;
        end
        p1_j_reg     <= j_reg;
        p1_l_reg     <= l_reg;
        p1_idx_reg   <= idx_reg;
        p1_last_reg  <= sw_last;
        p2_idx_reg   <= p1_idx_reg;
        p2_last_reg  <= p1_last_reg;
        p2_ds_v_reg  <= ds_v;
        p2_ds_p_reg  <= ds_p;
        p2_mt_en_reg <= rd_a[PW] && in_k && sym_ok;
        if (cmd.load_result)
        begin
            within_reg <= !ovf_reg && verd_reg;
            lovf_reg   <= ovf_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edit_limit_reg <= '0;
            m_reg          <= '0;
            n_reg          <= '0;
            ovf_reg        <= 1'b0;
            built_reg      <= 1'b0;
            bank_reg       <= 1'b0;
            verd_reg       <= 1'b0;
            b_run_reg      <= 1'b0;
            b_read_reg     <= 1'b0;
            bp_reg         <= '0;
            sw_run_reg     <= 1'b0;
            mode_reg       <= bedc_pkg::MODE_CLEAR;
            j_reg          <= '0;
            l_reg          <= '0;
            idx_reg        <= '0;
            p1_v_reg       <= 1'b0;
            p2_v_reg       <= 1'b0;
            hit_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                edit_limit_reg <= cfg_data;
            end
            if (cmd.clear)
            begin
                m_reg     <= '0;
                n_reg     <= '0;
                ovf_reg   <= 1'b0;
                built_reg <= 1'b0;
            end
            if (cmd.set_ovf)
            begin
                ovf_reg <= 1'b1;
            end
            if (cmd.tgt_store)
            begin
                m_reg <= m_reg + PW'(1);
            end

            // Backward scan: write a row, then fold in the symbol before it.
            if (cmd.build_start)
            begin
                b_run_reg  <= 1'b1;
                b_read_reg <= 1'b0;
                bp_reg     <= m_reg;
            end
            else if (b_write)
            begin
                if (bp_reg == '0)
                begin
                    b_run_reg <= 1'b0;
                    built_reg <= 1'b1;
                end
                else
                begin
                    bp_reg     <= bp_reg - PW'(1);
                    b_read_reg <= 1'b1;
                end
            end
            else if (b_run_reg)
            begin
                b_read_reg <= 1'b0;
            end

            if (sweep_start)
            begin
                sw_run_reg <= 1'b1;
                j_reg      <= '0;
                l_reg      <= '0;
                idx_reg    <= '0;
                hit_reg    <= 1'b0;
                if (cmd.clear)
                begin
                    mode_reg <= bedc_pkg::MODE_CLEAR;
                end
                else if (cmd.step_start)
                begin
                    mode_reg <= bedc_pkg::MODE_STEP;
                end
                else
                begin
                    mode_reg <= bedc_pkg::MODE_VERDICT;
                end
            end
            else if (sw_run_reg)
            begin
                idx_reg <= idx_reg + TW'(1);
                if (l_reg == j_reg)
                begin
                    j_reg <= j_reg + EW'(1);
                    l_reg <= '0;
                end
                else
                begin
                    l_reg <= l_reg + EW'(1);
                end
                if (sw_last)
                begin
                    sw_run_reg <= 1'b0;
                end
            end
            p1_v_reg <= sw_run_reg && !sweep_start;
            p2_v_reg <= p1_v_reg;

            if (p1_v_reg && (mode_reg == bedc_pkg::MODE_VERDICT) && e_hit)
            begin
                hit_reg <= 1'b1;
            end

            if (p2_v_reg && p2_last_reg)
            begin
                if (mode_reg == bedc_pkg::MODE_STEP)
                begin
                    bank_reg <= !bank_reg;
                    n_reg    <= n_reg + NW'(1);
                end
                if (mode_reg == bedc_pkg::MODE_VERDICT)
                begin
                    verd_reg <= hit_reg && !dist_over;
                end
            end
        end
    end

    assign st.built      = built_reg;
    assign st.tgt_full   = (32'(m_reg) >= MAX_TARGET);
    assign st.src_full   = (32'(n_reg) >= MAX_TARGET + MAX_EDITS);
    assign st.ovf        = ovf_reg;
    assign st.build_done = b_write && (bp_reg == '0);
    assign st.sweep_done = p2_v_reg && p2_last_reg;
    assign st.busy       = sw_run_reg || p1_v_reg || p2_v_reg || b_run_reg;

    assign within_limit    = within_reg;
    assign length_overflow = lovf_reg;

endmodule

@@ design/bounded_edit_distance_check.sv @@
// Top level of the bounded edit distance check.
// Depends on bedc_pkg, bedc_ctrl and bedc_dp.
`timescale 1ns / 1ps

// Usage:
// Items arrive on the in_valid/in_ready channel with operation and symbol.
// Clear empties both strings; target items load the target until the first
// source item; source items run one update of the reach table each; a finish
// item yields one result on the out_valid/out_ready channel (within_limit,
// length_overflow). An item beyond a string's capacity sets the overflow.
// The limit is written through cfg_valid/cfg_ready/cfg_data while idle; it is
// always ready and takes effect on the next item.
// Let T = (MAX_EDITS+1)(MAX_EDITS+2)/2, the size of the reach table.
// Clear sweeps all T entries; a source item runs a sweep that reads and writes
// one table entry per cycle, and the first source item after loading is
// preceded by the backward scan over the target. A finish item without
// overflow runs a verdict sweep before its result is loaded. After reset the
// block runs the same clearing pass over the table before in_ready rises. A
// result waits in its output register while the receiver stalls; other items
// are still taken meanwhile, and a second finish is taken but its result waits
// until the first result is transferred.

module bounded_edit_distance_check
#(
    parameter int MAX_TARGET = 1024,
    parameter int MAX_EDITS  = 20,
    parameter int ALPHABET   = 26
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] operation,
    input  logic [4:0] symbol,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       within_limit,
    output logic       length_overflow
);

    bedc_pkg::cmd_t    cmd;
    bedc_pkg::status_t st;

    assign cfg_ready = 1'b1;

    bedc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    bedc_dp
    #(
        .MAX_TARGET (MAX_TARGET),
        .MAX_EDITS  (MAX_EDITS),
        .ALPHABET   (ALPHABET)
    )
    u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .symbol          (symbol),
        .cmd             (cmd),
        .st              (st),
        .within_limit    (within_limit),
        .length_overflow (length_overflow)
    );

`ifndef SYNTHESIS
    // An overflowed run can never report a pass.
    a_ovf_forces_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && length_overflow |-> !within_limit)
        else $error("overflow result reported within limit");

    // Items are only taken when no sweep or scan is running.
    a_ready_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !st.busy)
        else $error("input ready while datapath busy");

    // A finish transfer always leaves the idle state.
    a_finish_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (operation == bedc_pkg::OP_FINISH) |=> !in_ready)
        else $error("finish did not leave idle");
`endif

endmodule

@@ dv/bedc_checker.sv @@
// Checker for the bounded edit distance check: watches the limit, item and
// verdict channels, predicts each verdict and compares it. Depends on bedc_pkg.
`timescale 1ns / 1ps

module bedc_checker
#(
    parameter int MAX_TARGET = 1024,
    parameter int MAX_EDITS  = 20,
    parameter int ALPHABET   = 26
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [4:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [1:0] operation,
    input  logic [4:0] symbol,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       within_limit,
    input  logic       length_overflow,
    output int         pending,
    output int         fail_count,
    output int         verdicts_checked
);

    typedef struct packed {
        logic in_limit;
        logic overflow;
    } verdict_t;

    verdict_t    verdict_q[$];
    logic [4:0]  limit_reg;
    logic [4:0]  target_str[MAX_TARGET];
    logic [10:0] next_pos[ALPHABET][MAX_TARGET + 1];
    logic [11:0] reach_pos[MAX_EDITS + 1][MAX_EDITS + 1];
    logic        reach_ok[MAX_EDITS + 1][MAX_EDITS + 1];
    logic [11:0] new_pos[MAX_EDITS + 1][MAX_EDITS + 1];
    logic        new_ok[MAX_EDITS + 1][MAX_EDITS + 1];
    int          target_len;
    int          source_len;
    logic        overflowed;
    logic        scan_done;
    int          fails;

    function automatic int active_limit();
        return (limit_reg > MAX_EDITS) ? MAX_EDITS : int'(limit_reg);
    endfunction

    function automatic void clear_strings();
        foreach (reach_ok[j, l])
            reach_ok[j][l] = 1'b0;
        reach_ok[0][0] = 1'b1;
        reach_pos[0][0] = '0;
        target_len = 0;
        source_len = 0;
        overflowed = 1'b0;
        scan_done = 1'b0;
    endfunction

    function automatic void scan_target();
        for (int c = 0; c < ALPHABET; c++)
        begin
            next_pos[c][target_len] = 11'(target_len);
            for (int p = target_len; p > 0; p--)
                next_pos[c][p - 1] = (target_str[p - 1] == c) ? 11'(p - 1) : next_pos[c][p];
        end
        scan_done = 1'b1;
    endfunction

    // Keep the leftmost target position offered to an entry.
    function automatic void offer_pos(int j, int l, logic [11:0] p);
        if (!new_ok[j][l] || p < new_pos[j][l])
        begin
            new_pos[j][l] = p;
            new_ok[j][l] = 1'b1;
        end
    endfunction

    function automatic void advance_source(logic [4:0] sym);
        int k;
        logic [11:0] p;
        logic [11:0] q;
        k = active_limit();
        foreach (new_ok[j, l])
            new_ok[j][l] = 1'b0;
        for (int j = 0; j <= k; j++)
        begin
            for (int l = 0; l <= j; l++)
            begin
                if (reach_ok[j][l])
                begin
                    p = reach_pos[j][l];
                    if (sym < ALPHABET)
                    begin
                        q = 12'(next_pos[sym][p]);
                        if (q < target_len)
                            offer_pos(j, l, q + 12'd1);
                    end
                    if (j < k)
                    begin
                        offer_pos(j + 1, l + 1, p);
                        if (p < target_len)
                            offer_pos(j + 1, l, p + 12'd1);
                    end
                end
            end
        end
        reach_pos = new_pos;
        reach_ok = new_ok;
    endfunction

    function automatic logic judge();
        int k;
        int d;
        int e;
        k = active_limit();
        d = source_len - target_len;
        if (d < 0)
            d = -d;
        if (d > k)
            return 1'b0;
        for (int j = 0; j <= k; j++)
        begin
            for (int l = 0; l <= j; l++)
            begin
                if (reach_ok[j][l])
                begin
                    // Target symbols skipped by free matches count as insertions.
                    e = (source_len - l) - target_len;
                    if (e < 0)
                        e = -e;
                    if (e <= k - j)
                        return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic void apply_item(bedc_pkg::op_t op, logic [4:0] sym);
        verdict_t v;
        case (op)
            bedc_pkg::OP_CLEAR: clear_strings();
            bedc_pkg::OP_TARGET:
            begin
                if (!scan_done)
                begin
                    if (target_len >= MAX_TARGET)
                    begin
                        overflowed = 1'b1;
                    end
                    else
                    begin
                        target_str[target_len] = sym;
                        target_len++;
                    end
                end
            end
            bedc_pkg::OP_SOURCE:
            begin
                if (source_len >= MAX_TARGET + MAX_EDITS)
                begin
                    overflowed = 1'b1;
                end
                else
                begin
                    if (!scan_done)
                        scan_target();
                    advance_source(sym);
                    source_len++;
                end
            end
            default:
            begin
                v.overflow = overflowed;
                v.in_limit = overflowed ? 1'b0 : judge();
                verdict_q.insert(verdict_q.size(), v);
            end
        endcase
    endfunction

    task automatic report(string what);
        $display("[%0t] mismatch: %s", $time, what);
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t v;
        if (!rst_n)
        begin
            limit_reg = '0;
            clear_strings();
            verdict_q.delete();
            fails = 0;
            verdicts_checked <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                limit_reg = cfg_data;
            if (in_valid && in_ready)
                apply_item(bedc_pkg::op_t'(operation), symbol);
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    report("verdict with none outstanding");
                end
                else
                begin
                    v = verdict_q.pop_front();
                    if (within_limit !== v.in_limit)
                        report($sformatf("within_limit expected %0b got %0b",
                                         v.in_limit, within_limit));
                    if (length_overflow !== v.overflow)
                        report($sformatf("length_overflow expected %0b got %0b",
                                         v.overflow, length_overflow));
                    verdicts_checked <= verdicts_checked + 1;
                end
            end
        end
        pending <= verdict_q.size();
        fail_count <= fails;
    end

endmodule

@@ dv/tb_bounded_edit_distance_check.sv @@
// Testbench top for the bounded edit distance check: drives items and limit
// writes, stalls the verdict channel. Depends on bedc_pkg, bedc_checker, RTL.
`timescale 1ns / 1ps

module tb_bounded_edit_distance_check;

    localparam int ITEM_GOAL = 1650;
    localparam int SETTLE = 300;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [4:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] operation;
    logic [4:0] symbol;
    logic       out_valid;
    logic       out_ready;
    logic       within_limit;
    logic       length_overflow;
    int         pending;
    int         fail_count;
    int         verdicts_checked;
    int         items_sent;
    int         burst_left;
    int         limit_writes;
    int         stall_count;
    bit         stall_mode;

    bounded_edit_distance_check u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .symbol         (symbol),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .within_limit   (within_limit),
        .length_overflow(length_overflow)
    );

    bedc_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .symbol          (symbol),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .within_limit    (within_limit),
        .length_overflow (length_overflow),
        .pending         (pending),
        .fail_count      (fail_count),
        .verdicts_checked(verdicts_checked)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // The receiver switches between free-running and random stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_count <= 0;
            stall_mode <= 1'b0;
        end
        else
        begin
            if (stall_count == 0)
            begin
                stall_count <= $urandom_range(50, 2000);
                stall_mode <= ~stall_mode;
            end
            else
            begin
                stall_count <= stall_count - 1;
            end
            out_ready <= stall_mode ? ($urandom_range(0, 7) == 0) : 1'b1;
        end
    end

    task automatic send(bedc_pkg::op_t op, logic [4:0] sym);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        operation <= op;
        symbol <= sym;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    // Wait until every verdict has come and the block has finished its sweep.
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_limit(logic [4:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_writes++;
    endtask

    function automatic logic [4:0] rand_letter();
        return ($urandom_range(0, 15) == 0) ? 5'($urandom_range(26, 31))
                                            : 5'($urandom_range(0, 25));
    endfunction

    function automatic logic [4:0] rand_limit();
        case ($urandom_range(0, 5))
            0: return 5'd0;
            1: return 5'd20;
            2: return 5'd31;
            default: return 5'($urandom_range(0, 8));
        endcase
    endfunction

    // One session: a target, a source derived from it by up to six random edits
    // or random, sometimes a limit change and an extra verdict at a random point.
    task automatic run_session();
        logic [4:0] tgt[$];
        logic [4:0] src[$];
        int tlen;
        int split;
        tlen = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
        for (int i = 0; i < tlen; i++)
            tgt.insert(tgt.size(), 5'($urandom_range(0, 5)));
        if ($urandom_range(0, 7) == 0)
        begin
            for (int i = 0; i < $urandom_range(0, 14); i++)
                src.insert(src.size(), rand_letter());
        end
        else
        begin
            src = tgt;
            for (int e = $urandom_range(0, 6); e > 0; e--)
            begin
                case ($urandom_range(0, 2))
                    0: src.insert($urandom_range(0, src.size()), rand_letter());
                    1: if (src.size() > 0) src.delete($urandom_range(0, src.size() - 1));
                    default:
                        if (src.size() > 0)
                            src[$urandom_range(0, src.size() - 1)] = rand_letter();
                endcase
            end
        end
        send(bedc_pkg::OP_CLEAR, 5'($urandom));
        foreach (tgt[i])
            send(bedc_pkg::OP_TARGET, tgt[i]);
        split = ($urandom_range(0, 3) == 0) ? $urandom_range(0, src.size()) : -1;
        foreach (src[i])
        begin
            if (i == split)
            begin
                send(bedc_pkg::OP_FINISH, 5'($urandom));
                write_limit(rand_limit());
            end
            send(bedc_pkg::OP_SOURCE, src[i]);
            if ($urandom_range(0, 30) == 0)
                send(bedc_pkg::OP_TARGET, rand_letter());
        end
        send(bedc_pkg::OP_FINISH, 5'($urandom));
        if ($urandom_range(0, 4) == 0)
            send(bedc_pkg::OP_FINISH, 5'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        operation = bedc_pkg::OP_CLEAR;
        symbol = '0;
        items_sent = 0;
        burst_left = 0;
        limit_writes = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty strings, matches, repeated and late items, odd symbols.
        write_limit(5'd0);
        send(bedc_pkg::OP_FINISH, 5'd0);
        send(bedc_pkg::OP_TARGET, 5'd0);
        send(bedc_pkg::OP_TARGET, 5'd25);
        send(bedc_pkg::OP_SOURCE, 5'd0);
        send(bedc_pkg::OP_SOURCE, 5'd25);
        send(bedc_pkg::OP_FINISH, 5'd31);
        send(bedc_pkg::OP_FINISH, 5'd0);
        send(bedc_pkg::OP_TARGET, 5'd3);
        send(bedc_pkg::OP_FINISH, 5'd0);
        write_limit(5'd31);
        send(bedc_pkg::OP_SOURCE, 5'd31);
        send(bedc_pkg::OP_SOURCE, 5'd26);
        send(bedc_pkg::OP_FINISH, 5'd0);
        send(bedc_pkg::OP_CLEAR, 5'd31);
        send(bedc_pkg::OP_TARGET, 5'd26);
        send(bedc_pkg::OP_TARGET, 5'd1);
        send(bedc_pkg::OP_FINISH, 5'd0);
        write_limit(5'd1);
        send(bedc_pkg::OP_SOURCE, 5'd26);
        send(bedc_pkg::OP_SOURCE, 5'd1);
        send(bedc_pkg::OP_FINISH, 5'd0);
        write_limit(5'd20);
        send(bedc_pkg::OP_CLEAR, 5'd0);
        send(bedc_pkg::OP_FINISH, 5'd0);

        // Target longer than capacity, then a source longer than capacity.
        send(bedc_pkg::OP_CLEAR, 5'd0);
        for (int i = 0; i < 1025; i++)
            send(bedc_pkg::OP_TARGET, rand_letter());
        send(bedc_pkg::OP_SOURCE, 5'd2);
        send(bedc_pkg::OP_FINISH, 5'd0);
        write_limit(5'd2);
        send(bedc_pkg::OP_CLEAR, 5'd0);
        send(bedc_pkg::OP_TARGET, 5'd4);
        for (int i = 0; i < 1045; i++)
            send(bedc_pkg::OP_SOURCE, rand_letter());
        send(bedc_pkg::OP_FINISH, 5'd0);

        while (items_sent < ITEM_GOAL + 900)
        begin
            if ($urandom_range(0, 2) == 0)
                write_limit(rand_limit());
            run_session();
        end

        settle();
        $display("Ran %0d items and %0d limit writes; %0d verdicts checked.",
                 items_sent, limit_writes, verdicts_checked);
        $display("Covered both overflow cases, odd symbols, late targets and limit changes.");
        if (fail_count == 0)
            $display("tb_bounded_edit_distance_check passed");
        else
            $display("tb_bounded_edit_distance_check failed");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("tb_bounded_edit_distance_check failed");
        $finish;
    end

endmodule
